[rtl/jdd_pkg.sv]
// Shared types and constants for the joystick to differential drive mixer.
package jdd_pkg;

    localparam int AXIS_W = 8;
    localparam int MAG_W  = AXIS_W;              // |axis| 0..128 fits unsigned
    localparam int DEN_W  = MAG_W + 1;           // |x|+|y| up to 256
    localparam int PROD_W = 2 * MAG_W;           // m*|axis| up to 16384
    localparam int QUO_W  = MAG_W;               // quotient 0..128
    localparam int DIV_STAGES = QUO_W;           // one quotient bit per stage

    typedef struct packed {
        logic signed [AXIS_W-1:0] x_axis;
        logic signed [AXIS_W-1:0] y_axis;
    } t_joy_req;

    typedef struct packed {
        logic signed [AXIS_W-1:0] left_drive;
        logic signed [AXIS_W-1:0] right_drive;
    } t_drive_res;

    // One divider stage, both axes in lockstep.
    typedef struct packed {
        logic              vld;
        logic              neg_x;
        logic              neg_y;
        logic [DEN_W-1:0]  den;
        logic [PROD_W-1:0] rem_x;
        logic [PROD_W-1:0] rem_y;
        logic [QUO_W-1:0]  quo_x;
        logic [QUO_W-1:0]  quo_y;
    } t_div_stage;

endpackage

[rtl/joystick_to_differential_drive.sv]
// Arcade drive mixer: joystick (x, y) to left and right motor drive values.
//
// Request channel: drive i_req and raise start; the request is taken at any
// rising edge where start is high and busy is low. busy is always low, so a
// new request can be issued in every cycle.
// Result channel: o_valid pulses for one cycle with o_res holding the left
// and right drive values; results leave in request order.
// Pipeline: one stage for magnitudes, max and divisor, one for the two
// 8x8 products, eight restoring-divider stages (one quotient bit each),
// and one for sign, sum and saturation.
// Throughput is one request per cycle.
// When x is zero the divider sees m = d = 1, so y passes straight through.
// Quotients are truncated toward zero; a drive of +128 saturates to 127.
// Synchronous active-low reset clears all stage valid bits; requests in
// flight are dropped. The receiver cannot stall, so no back-pressure exists.
module joystick_to_differential_drive (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  jdd_pkg::t_joy_req  i_req,
    output logic               o_valid,
    output jdd_pkg::t_drive_res o_res
);
    import jdd_pkg::*;

    localparam int LATENCY = DIV_STAGES + 3;

    // Stage 1: magnitudes, max, divisor
    logic             r_s1_vld;
    logic             r_s1_neg_x, r_s1_neg_y;
    logic [MAG_W-1:0] r_s1_ax, r_s1_ay, r_s1_m;
    logic [DEN_W-1:0] r_s1_den;

    logic [MAG_W-1:0] n_ax, n_ay, n_m;
    logic [DEN_W-1:0] n_den;
    logic             n_x_zero;

    assign busy = 1'b0;

    always_comb begin
        n_ax = i_req.x_axis[AXIS_W-1] ? MAG_W'(-i_req.x_axis) : MAG_W'(i_req.x_axis);
        n_ay = i_req.y_axis[AXIS_W-1] ? MAG_W'(-i_req.y_axis) : MAG_W'(i_req.y_axis);
        n_x_zero = (i_req.x_axis == '0);
        if (n_x_zero) begin
            n_m   = MAG_W'(1);
            n_den = DEN_W'(1);
        end else begin
            n_m   = (n_ax > n_ay) ? n_ax : n_ay;
            n_den = DEN_W'(n_ax) + DEN_W'(n_ay);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start & ~busy;
        end
        r_s1_neg_x <= i_req.x_axis[AXIS_W-1];
        r_s1_neg_y <= i_req.y_axis[AXIS_W-1];
        r_s1_ax    <= n_ax;
        r_s1_ay    <= n_ay;
        r_s1_m     <= n_m;
        r_s1_den   <= n_den;
    end

    // Stage 2 (divider stage 0): products; then one quotient bit per stage
    t_div_stage r_div [0:DIV_STAGES];
    t_div_stage n_div [0:DIV_STAGES];

    // Valid bits are cleared through the next-state path while in reset
    always_comb begin
        n_div[0].vld   = r_s1_vld & i_rst_n;
        n_div[0].neg_x = r_s1_neg_x;
        n_div[0].neg_y = r_s1_neg_y;
        n_div[0].den   = r_s1_den;
        n_div[0].rem_x = PROD_W'(r_s1_m) * PROD_W'(r_s1_ax);
        n_div[0].rem_y = PROD_W'(r_s1_m) * PROD_W'(r_s1_ay);
        n_div[0].quo_x = '0;
        n_div[0].quo_y = '0;
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        localparam int SH = DIV_STAGES - 1 - g;
        logic [PROD_W-1:0] w_trial;
        logic              w_bx, w_by;

        always_comb begin
            w_trial = PROD_W'(r_div[g].den) << SH;
            w_bx    = (r_div[g].rem_x >= w_trial);
            w_by    = (r_div[g].rem_y >= w_trial);
            n_div[g+1]       = r_div[g];
            n_div[g+1].vld   = r_div[g].vld & i_rst_n;
            n_div[g+1].rem_x = w_bx ? (r_div[g].rem_x - w_trial) : r_div[g].rem_x;
            n_div[g+1].rem_y = w_by ? (r_div[g].rem_y - w_trial) : r_div[g].rem_y;
            n_div[g+1].quo_x = {r_div[g].quo_x[QUO_W-2:0], w_bx};
            n_div[g+1].quo_y = {r_div[g].quo_y[QUO_W-2:0], w_by};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= DIV_STAGES; i++) begin
            r_div[i] <= n_div[i];
        end
    end

    // Output stage: restore signs, mix, saturate
    logic signed [QUO_W:0]   w_xs, w_ys;
    logic signed [QUO_W+1:0] w_left, w_right;
    t_drive_res              n_res;

    function automatic logic signed [AXIS_W-1:0] sat8(input logic signed [QUO_W+1:0] v);
        logic signed [QUO_W+1:0] hi, lo;
        hi = (QUO_W+2)'(2**(AXIS_W-1) - 1);
        lo = -(QUO_W+2)'(2**(AXIS_W-1));
        if (v > hi) begin
            sat8 = AXIS_W'(hi);
        end else if (v < lo) begin
            sat8 = AXIS_W'(lo);
        end else begin
            sat8 = AXIS_W'(v);
        end
    endfunction

    always_comb begin
        w_xs = r_div[DIV_STAGES].neg_x ? -$signed({1'b0, r_div[DIV_STAGES].quo_x})
                                       :  $signed({1'b0, r_div[DIV_STAGES].quo_x});
        w_ys = r_div[DIV_STAGES].neg_y ? -$signed({1'b0, r_div[DIV_STAGES].quo_y})
                                       :  $signed({1'b0, r_div[DIV_STAGES].quo_y});
        w_left  = (QUO_W+2)'(w_ys) + (QUO_W+2)'(w_xs);
        w_right = (QUO_W+2)'(w_ys) - (QUO_W+2)'(w_xs);
        n_res.left_drive  = sat8(w_left);
        n_res.right_drive = sat8(w_right);
    end

    t_drive_res r_res;
    logic       r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_div[DIV_STAGES].vld;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // A result only appears for a request that was taken earlier; the check looks back by LATENCY
    a_valid_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start & ~busy, LATENCY))
        else $error("result without matching request");

    // Zero x passes y straight through to both sides
    a_zero_x_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_req.x_axis, LATENCY) == '0) |->
        (o_res.left_drive == $past(i_req.y_axis, LATENCY) &&
         o_res.right_drive == $past(i_req.y_axis, LATENCY)))
        else $error("zero-x request did not pass y through");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the joystick to differential drive mixer.
`timescale 1ns / 100ps

module tb_top;
    import jdd_pkg::*;

    localparam int PIPE_LATENCY  = 11;
    localparam int DRAIN_CYCLES  = 2 * PIPE_LATENCY;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1500;

    // Expected drive values, kept in request order.
    class drive_scoreboard;
        t_drive_res  expected_drives[$];
        int unsigned mismatches = 0;

        function logic signed [AXIS_W-1:0] clamp_drive(int v);
            if (v > 127) v = 127;
            if (v < -128) v = -128;
            return v[AXIS_W-1:0];
        endfunction

        function t_drive_res mix_drive(t_joy_req r);
            int x;
            int y;
            int ax;
            int ay;
            int m;
            int d;
            int xs;
            int ys;
            t_drive_res res;
            x = $signed(r.x_axis);
            y = $signed(r.y_axis);
            if (x == 0) begin
                xs = 0;
                ys = y;
            end else begin
                ax = (x < 0) ? -x : x;
                ay = (y < 0) ? -y : y;
                m  = (ax > ay) ? ax : ay;
                d  = ax + ay;
                // SV integer division truncates toward zero
                xs = (m * x) / d;
                ys = (m * y) / d;
            end
            res.left_drive  = clamp_drive(ys + xs);
            res.right_drive = clamp_drive(ys - xs);
            return res;
        endfunction

        function void note_request(t_joy_req r);
            expected_drives.push_back(mix_drive(r));
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(t_drive_res got);
            t_drive_res want;
            if (expected_drives.size() == 0) begin
                flag_mismatch($sformatf("unexpected result left=%0d right=%0d",
                                        got.left_drive, got.right_drive));
                return;
            end
            want = expected_drives.pop_front();
            if (got.left_drive !== want.left_drive)
                flag_mismatch($sformatf("left_drive got %0d want %0d",
                                        got.left_drive, want.left_drive));
            if (got.right_drive !== want.right_drive)
                flag_mismatch($sformatf("right_drive got %0d want %0d",
                                        got.right_drive, want.right_drive));
        endtask
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_joy_req   i_req   = '0;
    logic       o_valid;
    t_drive_res o_res;

    drive_scoreboard drive_sb = new();
    int unsigned     stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    joystick_to_differential_drive u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) drive_sb.check_result(o_res);
            if (start && !busy) drive_sb.note_request(i_req);
        end
    end

    // Watchdog: cycles with no request taken and no result seen
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("joystick_to_differential_drive regression: fail");
                $finish;
            end
        end
    end

    // Called at a rising edge; returns at the edge that takes the request.
    task send_request(input logic signed [7:0] x, input logic signed [7:0] y);
        i_req.x_axis <= x;
        i_req.y_axis <= y;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task idle_gap(input int unsigned cycles);
        if (cycles != 0) begin
            start <= 1'b0;
            i_req <= t_joy_req'($urandom);   // junk while start is low
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function logic [7:0] random_axis_value();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h80;
            2: return 8'h7f;
            3: return 8'(signed'($urandom_range(0, 4)) - 2);
            default: return 8'($urandom);
        endcase
    endfunction

    task send_random();
        logic [7:0] x;
        logic [7:0] y;
        case ($urandom_range(0, 9))
            0: begin x = '0;       y = 8'($urandom); end
            1: begin x = 8'($urandom); y = '0;       end
            2: begin x = random_axis_value(); y = random_axis_value(); end
            default: begin x = 8'($urandom); y = 8'($urandom); end
        endcase
        send_request(x, y);
    endtask

    initial begin
        int unsigned sent;
        int unsigned burst;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: zero x, zero y, full-scale, saturation to 127
        send_request(8'sd0, 8'sd0);
        send_request(8'sd0, 8'sd127);
        send_request(8'sd0, -8'sd128);
        send_request(8'sd0, 8'sd1);
        send_request(8'sd0, -8'sd1);
        send_request(8'sd127, 8'sd0);
        send_request(-8'sd128, 8'sd0);
        send_request(8'sd1, 8'sd0);
        send_request(-8'sd1, 8'sd0);
        send_request(-8'sd128, -8'sd128);
        send_request(8'sd127, 8'sd127);
        send_request(-8'sd128, 8'sd127);
        send_request(8'sd127, -8'sd128);
        send_request(8'sd1, 8'sd1);
        send_request(-8'sd1, -8'sd1);
        send_request(8'sd1, -8'sd128);
        send_request(-8'sd128, 8'sd1);
        send_request(8'sd64, 8'sd64);
        send_request(-8'sd64, 8'sd32);
        send_request(8'sd3, -8'sd7);
        send_request(-8'sd100, 8'sd27);
        idle_gap(3);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
            repeat (burst) begin
                send_random();
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
        end

        start <= 1'b0;
        while (drive_sb.expected_drives.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (drive_sb.mismatches == 0 && drive_sb.expected_drives.size() == 0) begin
            $display("joystick_to_differential_drive regression: pass");
        end else begin
            $display("joystick_to_differential_drive regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/jdd_pkg.sv
rtl/joystick_to_differential_drive.sv
sim/tb_top.sv
